[hdl/c8_pkg.sv]
package c8_pkg;

  localparam int unsigned AddrW   = 12;
  localparam int unsigned RowAw   = 5;
  localparam int unsigned ScreenW = 64;
  localparam int unsigned RegAw   = 4;
  localparam int unsigned FontLen = 80;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_EXEC = 2'd1,
    MODE_ROW  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_FETCH_CAP,
    ST_READ_Y,
    ST_EXEC,
    ST_WRITE_F,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_BCD_H,
    ST_BCD_T,
    ST_BCD_O,
    ST_SAVE_RD,
    ST_SAVE_WR,
    ST_RESTORE_RD,
    ST_RESTORE_WR,
    ST_DONE
  } step_e;

  localparam logic [3:0] OP_SYS    = 4'h0;
  localparam logic [3:0] OP_JP     = 4'h1;
  localparam logic [3:0] OP_CALL   = 4'h2;
  localparam logic [3:0] OP_SE_I   = 4'h3;
  localparam logic [3:0] OP_SNE_I  = 4'h4;
  localparam logic [3:0] OP_SE_R   = 4'h5;
  localparam logic [3:0] OP_LD_I   = 4'h6;
  localparam logic [3:0] OP_ADD_I  = 4'h7;
  localparam logic [3:0] OP_ALU    = 4'h8;
  localparam logic [3:0] OP_SNE_R  = 4'h9;
  localparam logic [3:0] OP_LD_IDX = 4'hA;
  localparam logic [3:0] OP_JP_V0  = 4'hB;
  localparam logic [3:0] OP_RND    = 4'hC;
  localparam logic [3:0] OP_DRW    = 4'hD;
  localparam logic [3:0] OP_KEY    = 4'hE;
  localparam logic [3:0] OP_MISC   = 4'hF;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GET_DT = 8'h07;
  localparam logic [7:0] MISC_WAIT_K = 8'h0A;
  localparam logic [7:0] MISC_SET_DT = 8'h15;
  localparam logic [7:0] MISC_SET_ST = 8'h18;
  localparam logic [7:0] MISC_ADD_I  = 8'h1E;
  localparam logic [7:0] MISC_FONT   = 8'h29;
  localparam logic [7:0] MISC_BCD    = 8'h33;
  localparam logic [7:0] MISC_SAVE   = 8'h55;
  localparam logic [7:0] MISC_LOAD   = 8'h65;

  localparam logic [7:0] FONT [FontLen] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic        redraw_pending;
    logic [63:0] row_pixels;
    logic [7:0]  delay_count;
    logic [7:0]  sound_count;
  } out_item_t;

  typedef struct packed {
    step_e             step;
    logic [AddrW-1:0]  cnt;
    logic              take_in;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic [15:0] opcode;
  } status_t;

endpackage

[hdl/c8_ctrl.sv]
module c8_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  c8_pkg::status_t  status_i,
  output c8_pkg::cmd_t     cmd_o
);

  c8_pkg::step_e                state_q, state_d;
  logic [c8_pkg::AddrW-1:0]     cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         take_in, load_out;
  logic [3:0]                   op_hi, op_x, op_n;
  logic [7:0]                   op_nn;

  assign op_hi = status_i.opcode[15:12];
  assign op_x  = status_i.opcode[11:8];
  assign op_n  = status_i.opcode[3:0];
  assign op_nn = status_i.opcode[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c8_pkg::ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    take_in     = 1'b0;
    load_out    = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      c8_pkg::ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = c8_pkg::ST_IDLE;
        end
      end
      c8_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          take_in = 1'b1;
          unique case (c8_pkg::mode_e'(in_mode_i))
            c8_pkg::MODE_LOAD: state_d = c8_pkg::ST_LOAD;
            c8_pkg::MODE_EXEC: state_d = c8_pkg::ST_FETCH_HI;
            c8_pkg::MODE_ROW:  state_d = c8_pkg::ST_ROW_RD;
            default:           state_d = c8_pkg::ST_DONE;
          endcase
        end
      end
      c8_pkg::ST_LOAD:      state_d = c8_pkg::ST_DONE;
      c8_pkg::ST_ROW_RD:    state_d = c8_pkg::ST_ROW_CAP;
      c8_pkg::ST_ROW_CAP:   state_d = c8_pkg::ST_DONE;
      c8_pkg::ST_FETCH_HI:  state_d = c8_pkg::ST_FETCH_LO;
      c8_pkg::ST_FETCH_LO:  state_d = c8_pkg::ST_FETCH_CAP;
      c8_pkg::ST_FETCH_CAP: state_d = c8_pkg::ST_READ_Y;
      c8_pkg::ST_READ_Y:    state_d = c8_pkg::ST_EXEC;
      c8_pkg::ST_EXEC: begin
        cnt_d   = '0;
        state_d = c8_pkg::ST_DONE;
        unique case (op_hi)
          c8_pkg::OP_ALU: begin
            case (op_n)
              c8_pkg::ALU_ADD, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR,
              c8_pkg::ALU_SBN, c8_pkg::ALU_SHL: state_d = c8_pkg::ST_WRITE_F;
              default: ;
            endcase
          end
          c8_pkg::OP_DRW: begin
            state_d = (op_n == '0) ? c8_pkg::ST_WRITE_F : c8_pkg::ST_DRAW_RD;
          end
          c8_pkg::OP_MISC: begin
            case (op_nn)
              c8_pkg::MISC_BCD:  state_d = c8_pkg::ST_BCD_H;
              c8_pkg::MISC_SAVE: state_d = c8_pkg::ST_SAVE_RD;
              c8_pkg::MISC_LOAD: state_d = c8_pkg::ST_RESTORE_RD;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8_pkg::ST_WRITE_F: state_d = c8_pkg::ST_DONE;
      c8_pkg::ST_DRAW_RD: state_d = c8_pkg::ST_DRAW_WR;
      c8_pkg::ST_DRAW_WR: begin
        if (cnt_q[3:0] == op_n - 4'd1) begin
          state_d = c8_pkg::ST_WRITE_F;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = c8_pkg::ST_DRAW_RD;
        end
      end
      c8_pkg::ST_BCD_H: state_d = c8_pkg::ST_BCD_T;
      c8_pkg::ST_BCD_T: state_d = c8_pkg::ST_BCD_O;
      c8_pkg::ST_BCD_O: state_d = c8_pkg::ST_DONE;
      c8_pkg::ST_SAVE_RD: state_d = c8_pkg::ST_SAVE_WR;
      c8_pkg::ST_SAVE_WR: begin
        if (cnt_q[3:0] == op_x) begin
          state_d = c8_pkg::ST_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = c8_pkg::ST_SAVE_RD;
        end
      end
      c8_pkg::ST_RESTORE_RD: state_d = c8_pkg::ST_RESTORE_WR;
      c8_pkg::ST_RESTORE_WR: begin
        if (cnt_q[3:0] == op_x) begin
          state_d = c8_pkg::ST_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = c8_pkg::ST_RESTORE_RD;
        end
      end
      c8_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = c8_pkg::ST_IDLE;
        end
      end
      default: state_d = c8_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.step     = state_q;
  assign cmd_o.cnt      = cnt_q;
  assign cmd_o.take_in  = take_in;
  assign cmd_o.load_out = load_out;

endmodule

[hdl/c8_dp.sv]
module c8_dp #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned PROGRAM_START = 512,
  parameter int unsigned FONT_BASE     = 80
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c8_pkg::in_item_t   in_i,
  input  c8_pkg::cmd_t       cmd_i,
  output c8_pkg::status_t    status_o,
  output c8_pkg::out_item_t  out_o
);

  localparam int unsigned MemBytes = 2 ** c8_pkg::AddrW;
  localparam int unsigned ScreenH  = 2 ** c8_pkg::RowAw;
  localparam int unsigned RegN     = 2 ** c8_pkg::RegAw;
  localparam int unsigned SpW      = $clog2(STACK_DEPTH);
  localparam int unsigned W        = c8_pkg::ScreenW;
  localparam logic [SpW-1:0]           SpLast   = SpW'(STACK_DEPTH - 1);
  localparam logic [c8_pkg::AddrW-1:0] PcStart  = c8_pkg::AddrW'(PROGRAM_START);
  localparam logic [c8_pkg::AddrW-1:0] FontBase = c8_pkg::AddrW'(FONT_BASE);
  localparam logic [c8_pkg::AddrW-1:0] FontEnd  = c8_pkg::AddrW'(FONT_BASE + c8_pkg::FontLen);

  logic [7:0]                mem [MemBytes];
  logic [7:0]                mem_rdata_q;
  logic                      mem_we;
  logic [c8_pkg::AddrW-1:0]  mem_wa, mem_ra;
  logic [7:0]                mem_wd;

  logic [7:0]                v_mem [RegN];
  logic [RegN-1:0]           v_vld_q;
  logic [7:0]                v_rdata_q;
  logic                      v_rvld_q;
  logic                      v_we;
  logic [c8_pkg::RegAw-1:0]  v_wa, v_ra;
  logic [7:0]                v_wd, v_rd;

  logic [W-1:0]              fb_mem [ScreenH];
  logic [ScreenH-1:0]        fb_vld_q;
  logic [W-1:0]              fb_rdata_q;
  logic                      fb_rvld_q;
  logic                      fb_we, fb_clr;
  logic [c8_pkg::RowAw-1:0]  fb_ra, fb_row;
  logic [W-1:0]              fb_wd, fb_rd;

  c8_pkg::in_item_t          in_q;
  c8_pkg::out_item_t         out_q;
  logic [15:0]               opcode_q;
  logic [7:0]                hi_q, vx_q, vy_q;
  logic                      flag_q, flag_d;
  logic [W-1:0]              row_q;

  logic [c8_pkg::AddrW-1:0]  pc_q, pc_d, i_q, i_d;
  logic [SpW-1:0]            sp_q, sp_d, sp_inc, sp_dec;
  logic [c8_pkg::AddrW-1:0]  stack_q [STACK_DEPTH];
  logic                      push;
  logic [7:0]                delay_q, delay_d, sound_q, sound_d;
  logic                      redraw_q, redraw_d;

  logic [3:0]                op_x, op_y, op_n;
  logic [7:0]                op_nn, vy;
  logic [c8_pkg::AddrW-1:0]  op_nnn, i_cnt;
  logic [8:0]                sum9;
  logic                      held, key_any;
  logic [3:0]                key_idx;
  logic [c8_pkg::AddrW-1:0]  font_off;
  logic [7:0]                clr_byte;
  logic [19:0]               hund_p, tens_p;
  logic [1:0]                bcd_h;
  logic [4:0]                bcd_q10;
  logic [7:0]                bcd_t, bcd_o;
  logic [2*W-1:0]            spr_dbl;
  logic [W-1:0]              spr_mask;

  assign op_x   = opcode_q[11:8];
  assign op_y   = opcode_q[7:4];
  assign op_n   = opcode_q[3:0];
  assign op_nn  = opcode_q[7:0];
  assign op_nnn = opcode_q[11:0];
  assign vy     = v_rd;
  assign i_cnt  = i_q + cmd_i.cnt;
  assign v_rd   = v_rvld_q ? v_rdata_q : 8'h00;
  assign fb_rd  = fb_rvld_q ? fb_rdata_q : '0;
  assign sp_inc = (sp_q == SpLast) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SpLast : sp_q - 1'b1;

  assign font_off = cmd_i.cnt - FontBase;
  assign clr_byte = (cmd_i.cnt >= FontBase && cmd_i.cnt < FontEnd) ?
                    c8_pkg::FONT[font_off[6:0]] : 8'h00;

  assign hund_p  = {12'd0, vx_q} * 20'd41;
  assign tens_p  = {12'd0, vx_q} * 20'd205;
  assign bcd_h   = hund_p[13:12];
  assign bcd_q10 = tens_p[15:11];
  assign bcd_t   = {3'd0, bcd_q10} - 8'({bcd_h, 3'd0} + {bcd_h, 1'b0});
  assign bcd_o   = vx_q - 8'({bcd_q10, 3'd0} + {bcd_q10, 1'b0});

  assign fb_row   = vy_q[c8_pkg::RowAw-1:0] + cmd_i.cnt[c8_pkg::RowAw-1:0];
  assign spr_dbl  = {mem_rdata_q, {(W-8){1'b0}}, mem_rdata_q, {(W-8){1'b0}}} >> vx_q[5:0];
  assign spr_mask = spr_dbl[W-1:0];

  always_comb begin
    key_idx = '0;
    for (int k = RegN - 1; k >= 0; k--) begin
      if (in_q.key_mask[k]) key_idx = 4'(k);
    end
  end
  assign key_any = |in_q.key_mask;
  assign held    = in_q.key_mask[vx_q[3:0]];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = in_q.load_address;
    mem_wd = in_q.load_byte;
    mem_ra = pc_q;
    case (cmd_i.step)
      c8_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cmd_i.cnt;
        mem_wd = clr_byte;
      end
      c8_pkg::ST_LOAD:       mem_we = 1'b1;
      c8_pkg::ST_FETCH_LO:   mem_ra = pc_q + 1'b1;
      c8_pkg::ST_DRAW_RD,
      c8_pkg::ST_RESTORE_RD: mem_ra = i_cnt;
      c8_pkg::ST_BCD_H: begin
        mem_we = 1'b1;
        mem_wa = i_q;
        mem_wd = {6'd0, bcd_h};
      end
      c8_pkg::ST_BCD_T: begin
        mem_we = 1'b1;
        mem_wa = i_q + 1'b1;
        mem_wd = bcd_t;
      end
      c8_pkg::ST_BCD_O: begin
        mem_we = 1'b1;
        mem_wa = i_q + 2'd2;
        mem_wd = bcd_o;
      end
      c8_pkg::ST_SAVE_WR: begin
        mem_we = 1'b1;
        mem_wa = i_cnt;
        mem_wd = v_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rdata_q <= mem[mem_ra];
  end

  always_comb begin
    v_ra = '0;
    case (cmd_i.step)
      c8_pkg::ST_FETCH_CAP: v_ra = hi_q[3:0];
      c8_pkg::ST_READ_Y:    v_ra = (opcode_q[15:12] == c8_pkg::OP_JP_V0) ? '0 : op_y;
      c8_pkg::ST_SAVE_RD:   v_ra = cmd_i.cnt[c8_pkg::RegAw-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) v_mem[v_wa] <= v_wd;
    v_rdata_q <= v_mem[v_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q  <= '0;
      v_rvld_q <= 1'b0;
    end else begin
      v_rvld_q <= v_vld_q[v_ra];
      if (v_we) v_vld_q[v_wa] <= 1'b1;
    end
  end

  always_comb begin
    fb_ra = fb_row;
    fb_we = 1'b0;
    fb_wd = fb_rd ^ spr_mask;
    if (cmd_i.step == c8_pkg::ST_ROW_RD) fb_ra = in_q.row_select;
    if (cmd_i.step == c8_pkg::ST_DRAW_WR) fb_we = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_row] <= fb_wd;
    fb_rdata_q <= fb_mem[fb_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_vld_q  <= '0;
      fb_rvld_q <= 1'b0;
    end else begin
      fb_rvld_q <= fb_vld_q[fb_ra];
      if (fb_clr) begin
        fb_vld_q <= '0;
      end else if (fb_we) begin
        fb_vld_q[fb_row] <= 1'b1;
      end
    end
  end

  always_comb begin
    pc_d     = pc_q;
    i_d      = i_q;
    sp_d     = sp_q;
    push     = 1'b0;
    delay_d  = delay_q;
    sound_d  = sound_q;
    redraw_d = redraw_q;
    flag_d   = flag_q;
    fb_clr   = 1'b0;
    v_we     = 1'b0;
    v_wa     = op_x;
    v_wd     = op_nn;
    sum9     = {1'b0, vx_q} + {1'b0, vy};
    case (cmd_i.step)
      c8_pkg::ST_FETCH_CAP: pc_d = pc_q + 2'd2;
      c8_pkg::ST_EXEC: begin
        unique case (opcode_q[15:12])
          c8_pkg::OP_SYS: begin
            if (opcode_q == c8_pkg::OPC_CLS) begin
              fb_clr   = 1'b1;
              redraw_d = 1'b1;
            end else if (opcode_q == c8_pkg::OPC_RET) begin
              sp_d = sp_dec;
              pc_d = stack_q[sp_dec];
            end
          end
          c8_pkg::OP_JP: pc_d = op_nnn;
          c8_pkg::OP_CALL: begin
            push = 1'b1;
            sp_d = sp_inc;
            pc_d = op_nnn;
          end
          c8_pkg::OP_SE_I:  if (vx_q == op_nn) pc_d = pc_q + 2'd2;
          c8_pkg::OP_SNE_I: if (vx_q != op_nn) pc_d = pc_q + 2'd2;
          c8_pkg::OP_SE_R:  if (op_n == '0 && vx_q == vy) pc_d = pc_q + 2'd2;
          c8_pkg::OP_LD_I:  v_we = 1'b1;
          c8_pkg::OP_ADD_I: begin
            v_we = 1'b1;
            v_wd = vx_q + op_nn;
          end
          c8_pkg::OP_ALU: begin
            case (op_n)
              c8_pkg::ALU_MOV: begin
                v_we = 1'b1;
                v_wd = vy;
              end
              c8_pkg::ALU_OR: begin
                v_we = 1'b1;
                v_wd = vx_q | vy;
              end
              c8_pkg::ALU_AND: begin
                v_we = 1'b1;
                v_wd = vx_q & vy;
              end
              c8_pkg::ALU_XOR: begin
                v_we = 1'b1;
                v_wd = vx_q ^ vy;
              end
              c8_pkg::ALU_ADD: begin
                v_we   = 1'b1;
                v_wd   = sum9[7:0];
                flag_d = sum9[8];
              end
              c8_pkg::ALU_SUB: begin
                v_we   = 1'b1;
                v_wd   = vx_q - vy;
                flag_d = vx_q >= vy;
              end
              c8_pkg::ALU_SHR: begin
                v_we   = 1'b1;
                v_wd   = {1'b0, vx_q[7:1]};
                flag_d = vx_q[0];
              end
              c8_pkg::ALU_SBN: begin
                v_we   = 1'b1;
                v_wd   = vy - vx_q;
                flag_d = vy >= vx_q;
              end
              c8_pkg::ALU_SHL: begin
                v_we   = 1'b1;
                v_wd   = {vx_q[6:0], 1'b0};
                flag_d = vx_q[7];
              end
              default: ;
            endcase
          end
          c8_pkg::OP_SNE_R:  if (op_n == '0 && vx_q != vy) pc_d = pc_q + 2'd2;
          c8_pkg::OP_LD_IDX: i_d = op_nnn;
          c8_pkg::OP_JP_V0:  pc_d = op_nnn + {4'd0, vy};
          c8_pkg::OP_RND: begin
            v_we = 1'b1;
            v_wd = in_q.random_byte & op_nn;
          end
          c8_pkg::OP_DRW: flag_d = 1'b0;
          c8_pkg::OP_KEY: begin
            if ((op_nn == c8_pkg::KEY_SKP && held) ||
                (op_nn == c8_pkg::KEY_SKNP && !held)) begin
              pc_d = pc_q + 2'd2;
            end
          end
          c8_pkg::OP_MISC: begin
            case (op_nn)
              c8_pkg::MISC_GET_DT: begin
                v_we = 1'b1;
                v_wd = delay_q;
              end
              c8_pkg::MISC_WAIT_K: begin
                if (key_any) begin
                  v_we = 1'b1;
                  v_wd = {4'd0, key_idx};
                end else begin
                  pc_d = pc_q - 2'd2;
                end
              end
              c8_pkg::MISC_SET_DT: delay_d = vx_q;
              c8_pkg::MISC_SET_ST: sound_d = vx_q;
              c8_pkg::MISC_ADD_I:  i_d = i_q + {4'd0, vx_q};
              c8_pkg::MISC_FONT: begin
                i_d = FontBase + {6'd0, vx_q[3:0], 2'd0} + {8'd0, vx_q[3:0]};
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8_pkg::ST_WRITE_F: begin
        v_we = 1'b1;
        v_wa = 4'hF;
        v_wd = {7'd0, flag_q};
      end
      c8_pkg::ST_DRAW_WR: begin
        flag_d   = flag_q | (|(fb_rd & spr_mask));
        redraw_d = 1'b1;
      end
      c8_pkg::ST_RESTORE_WR: begin
        v_we = 1'b1;
        v_wa = cmd_i.cnt[c8_pkg::RegAw-1:0];
        v_wd = mem_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PcStart;
      i_q      <= '0;
      sp_q     <= '0;
      delay_q  <= '0;
      sound_q  <= '0;
      redraw_q <= 1'b0;
      for (int s = 0; s < STACK_DEPTH; s++) stack_q[s] <= '0;
    end else begin
      pc_q     <= pc_d;
      i_q      <= i_d;
      sp_q     <= sp_d;
      delay_q  <= delay_d;
      sound_q  <= sound_d;
      redraw_q <= redraw_d;
      if (push) stack_q[sp_q] <= pc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    if (cmd_i.take_in) in_q <= in_i;
    if (cmd_i.step == c8_pkg::ST_FETCH_LO) hi_q <= mem_rdata_q;
    if (cmd_i.step == c8_pkg::ST_FETCH_CAP) opcode_q <= {hi_q, mem_rdata_q};
    if (cmd_i.step == c8_pkg::ST_READ_Y) vx_q <= v_rd;
    if (cmd_i.step == c8_pkg::ST_EXEC) vy_q <= vy;
    if (cmd_i.step == c8_pkg::ST_ROW_CAP) row_q <= fb_rd;
    if (cmd_i.load_out) begin
      out_q.program_counter <= pc_q;
      out_q.executed_opcode <= (in_q.mode == c8_pkg::MODE_EXEC) ? opcode_q : '0;
      out_q.redraw_pending  <= redraw_q;
      out_q.row_pixels      <= (in_q.mode == c8_pkg::MODE_ROW) ? row_q : '0;
      out_q.delay_count     <= delay_q;
      out_q.sound_count     <= sound_q;
    end
  end

  assign status_o.opcode = opcode_q;
  assign out_o           = out_q;

endmodule

[hdl/chip8_instruction_core_unit.sv]
// CHIP-8 interpreter core: each input transaction loads one memory byte, executes one
// instruction, reads one display row or, in MODE_NONE, changes nothing, and returns
// exactly one result transaction. After reset the core sweeps all of main memory (zero,
// hex font at FONT_BASE) and takes no transaction until that pass ends. Afterwards an
// instruction fetches its two opcode bytes and reads Vx then Vy one after another, set
// by the single read port of main memory and of the register file. A sprite draw adds
// a read and a write per sprite row, BCD a write per digit, and FX55/FX65 a read and a
// write per register. The next transaction is accepted while the previous result still
// waits in the output register.
module chip8_instruction_core_unit #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned PROGRAM_START = 512,
  parameter int unsigned FONT_BASE     = 80
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  c8_pkg::in_item_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output c8_pkg::out_item_t  out_o
);

  c8_pkg::cmd_t    cmd;
  c8_pkg::status_t status;

  c8_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  c8_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_START (PROGRAM_START),
    .FONT_BASE     (FONT_BASE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule

[test/chip8_instruction_core_checker.sv]
module chip8_instruction_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  c8_pkg::in_item_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  c8_pkg::out_item_t out_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_seen_o
);

  localparam int unsigned StackDepth = 16;
  localparam logic [11:0] ProgStart  = 12'h200;
  localparam logic [11:0] FontBase   = 12'h050;

  logic [7:0]  mem [4096];
  logic [7:0]  v [16];
  logic [11:0] idx_reg;
  logic [11:0] pc_reg;
  logic [11:0] stack [StackDepth];
  logic [3:0]  sp;
  logic [63:0] screen [32];
  logic [7:0]  delay_reg;
  logic [7:0]  sound_reg;
  logic        redraw;

  c8_pkg::out_item_t expected_results [$];

  function automatic logic [7:0] hex_glyph(int i);
    logic [7:0] g [80];
    g = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
          8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
          8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    return g[i];
  endfunction

  task automatic clear_core();
    for (int i = 0; i < 4096; i++) mem[i] = '0;
    for (int i = 0; i < 80; i++) mem[12'(FontBase + i)] = hex_glyph(i);
    for (int i = 0; i < 16; i++) begin
      v[i] = '0;
      stack[i] = '0;
    end
    for (int i = 0; i < 32; i++) screen[i] = '0;
    idx_reg = '0;
    pc_reg = ProgStart;
    sp = '0;
    delay_reg = '0;
    sound_reg = '0;
    redraw = 1'b0;
  endtask

  task automatic draw(logic [3:0] xr, logic [3:0] yr, logic [3:0] rows);
    logic [5:0]  x0;
    logic [4:0]  y0;
    logic [7:0]  bits;
    logic [63:0] m;
    logic        hit;
    x0 = v[xr][5:0];
    y0 = v[yr][4:0];
    hit = 1'b0;
    for (int r = 0; r < rows; r++) begin
      bits = mem[12'(idx_reg + r)];
      for (int c = 0; c < 8; c++) begin
        if (bits[7-c]) begin
          m = 64'd1 << (63 - 6'(x0 + c));
          if ((screen[5'(y0 + r)] & m) != 0) hit = 1'b1;
          screen[5'(y0 + r)] ^= m;
        end
      end
    end
    if (rows != 0) redraw = 1'b1;
    v[15] = {7'd0, hit};
  endtask

  task automatic alu(logic [3:0] x, logic [3:0] y, logic [3:0] op);
    logic [7:0] a, b;
    logic       f;
    a = v[x];
    b = v[y];
    case (op)
      c8_pkg::ALU_MOV: v[x] = b;
      c8_pkg::ALU_OR:  v[x] = a | b;
      c8_pkg::ALU_AND: v[x] = a & b;
      c8_pkg::ALU_XOR: v[x] = a ^ b;
      c8_pkg::ALU_ADD: begin
        f = (9'(a) + 9'(b)) > 9'd255;
        v[x] = a + b;
        v[15] = {7'd0, f};
      end
      c8_pkg::ALU_SUB: begin
        f = a >= b;
        v[x] = a - b;
        v[15] = {7'd0, f};
      end
      c8_pkg::ALU_SHR: begin
        f = a[0];
        v[x] = a >> 1;
        v[15] = {7'd0, f};
      end
      c8_pkg::ALU_SBN: begin
        f = b >= a;
        v[x] = b - a;
        v[15] = {7'd0, f};
      end
      c8_pkg::ALU_SHL: begin
        f = a[7];
        v[x] = a << 1;
        v[15] = {7'd0, f};
      end
      default: ;
    endcase
  endtask

  task automatic misc(logic [3:0] x, logic [7:0] nn, logic [15:0] keys);
    logic found;
    case (nn)
      c8_pkg::MISC_GET_DT: v[x] = delay_reg;
      c8_pkg::MISC_WAIT_K: begin
        found = 1'b0;
        for (int i = 0; i < 16; i++) begin
          if (!found && keys[i]) begin
            v[x] = 8'(i);
            found = 1'b1;
          end
        end
        if (!found) pc_reg = pc_reg - 12'd2;
      end
      c8_pkg::MISC_SET_DT: delay_reg = v[x];
      c8_pkg::MISC_SET_ST: sound_reg = v[x];
      c8_pkg::MISC_ADD_I:  idx_reg = idx_reg + 12'(v[x]);
      c8_pkg::MISC_FONT:   idx_reg = FontBase + 12'(5 * v[x][3:0]);
      c8_pkg::MISC_BCD: begin
        mem[idx_reg] = v[x] / 100;
        mem[12'(idx_reg + 1)] = (v[x] / 10) % 10;
        mem[12'(idx_reg + 2)] = v[x] % 10;
      end
      c8_pkg::MISC_SAVE: for (int i = 0; i <= x; i++) mem[12'(idx_reg + i)] = v[i];
      c8_pkg::MISC_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[12'(idx_reg + i)];
      default: ;
    endcase
  endtask

  task automatic run_instruction(logic [15:0] keys, logic [7:0] rnd, output logic [15:0] op);
    logic [3:0]  x, y, n;
    logic [7:0]  nn;
    op = {mem[pc_reg], mem[12'(pc_reg + 1)]};
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    pc_reg = pc_reg + 12'd2;
    case (op[15:12])
      c8_pkg::OP_SYS: begin
        if (op == c8_pkg::OPC_CLS) begin
          for (int i = 0; i < 32; i++) screen[i] = '0;
          redraw = 1'b1;
        end else if (op == c8_pkg::OPC_RET) begin
          sp = sp - 4'd1;
          pc_reg = stack[sp];
        end
      end
      c8_pkg::OP_JP: pc_reg = op[11:0];
      c8_pkg::OP_CALL: begin
        stack[sp] = pc_reg;
        sp = sp + 4'd1;
        pc_reg = op[11:0];
      end
      c8_pkg::OP_SE_I:   if (v[x] == nn) pc_reg += 12'd2;
      c8_pkg::OP_SNE_I:  if (v[x] != nn) pc_reg += 12'd2;
      c8_pkg::OP_SE_R:   if (n == 0 && v[x] == v[y]) pc_reg += 12'd2;
      c8_pkg::OP_LD_I:   v[x] = nn;
      c8_pkg::OP_ADD_I:  v[x] = v[x] + nn;
      c8_pkg::OP_ALU:    alu(x, y, n);
      c8_pkg::OP_SNE_R:  if (n == 0 && v[x] != v[y]) pc_reg += 12'd2;
      c8_pkg::OP_LD_IDX: idx_reg = op[11:0];
      c8_pkg::OP_JP_V0:  pc_reg = op[11:0] + 12'(v[0]);
      c8_pkg::OP_RND:    v[x] = rnd & nn;
      c8_pkg::OP_DRW:    draw(x, y, n);
      c8_pkg::OP_KEY: begin
        if ((nn == c8_pkg::KEY_SKP && keys[v[x][3:0]]) ||
            (nn == c8_pkg::KEY_SKNP && !keys[v[x][3:0]]))
          pc_reg += 12'd2;
      end
      default: misc(x, nn, keys);
    endcase
  endtask

  task automatic predict_step(c8_pkg::in_item_t it);
    c8_pkg::out_item_t r;
    logic [15:0] op;
    op = '0;
    r = '0;
    case (c8_pkg::mode_e'(it.mode))
      c8_pkg::MODE_LOAD: mem[it.load_address] = it.load_byte;
      c8_pkg::MODE_EXEC: run_instruction(it.key_mask, it.random_byte, op);
      c8_pkg::MODE_ROW:  r.row_pixels = screen[it.row_select];
      default: ;
    endcase
    r.program_counter = pc_reg;
    r.executed_opcode = op;
    r.redraw_pending = redraw;
    r.delay_count = delay_reg;
    r.sound_count = sound_reg;
    expected_results.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
  endtask

  task automatic compare_result(c8_pkg::out_item_t got);
    c8_pkg::out_item_t e;
    if (expected_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected result transaction %h", got);
      return;
    end
    e = expected_results.pop_front();
    if (got.program_counter != e.program_counter)
      report("program_counter", 64'(e.program_counter), 64'(got.program_counter));
    if (got.executed_opcode != e.executed_opcode)
      report("executed_opcode", 64'(e.executed_opcode), 64'(got.executed_opcode));
    if (got.redraw_pending !== e.redraw_pending)
      report("redraw_pending", 64'(e.redraw_pending), 64'(got.redraw_pending));
    if (got.row_pixels != e.row_pixels)
      report("row_pixels", e.row_pixels, got.row_pixels);
    if (got.delay_count != e.delay_count)
      report("delay_count", 64'(e.delay_count), 64'(got.delay_count));
    if (got.sound_count != e.sound_count)
      report("sound_count", 64'(e.sound_count), 64'(got.sound_count));
  endtask

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
    clear_core();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_step(in_i);
      if (out_valid_i && out_ready_i) begin
        compare_result(out_i);
        results_seen_o++;
      end
    end
  end

  assign pending_o = expected_results.size();

endmodule

[test/tb_chip8_instruction_core_unit.sv]
module tb_chip8_instruction_core_unit;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned IdleLimit   = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  c8_pkg::in_item_t  in_item;
  logic              out_valid;
  logic              out_ready;
  c8_pkg::out_item_t out_item;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       results_seen;
  int unsigned       idle_cycles;
  int unsigned       sent;
  logic              stim_done;

  chip8_instruction_core_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  chip8_instruction_core_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_i           (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_i          (out_item),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(c8_pkg::in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      in_item <= '0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    in_item <= '0;
    @(posedge clk);
  endtask

  function automatic c8_pkg::in_item_t noise_item(logic [1:0] m);
    c8_pkg::in_item_t it;
    it.mode = m;
    it.load_address = 12'($urandom);
    it.load_byte = 8'($urandom);
    it.key_mask = 16'($urandom);
    it.random_byte = 8'($urandom);
    it.row_select = 5'($urandom);
    return it;
  endfunction

  task automatic load_byte(logic [11:0] a, logic [7:0] b);
    c8_pkg::in_item_t it;
    it = noise_item(c8_pkg::MODE_LOAD);
    it.load_address = a;
    it.load_byte = b;
    send(it);
  endtask

  task automatic exec_one(logic [15:0] keys);
    c8_pkg::in_item_t it;
    it = noise_item(c8_pkg::MODE_EXEC);
    it.key_mask = keys;
    send(it);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(0, 15))
      0:  op = $urandom_range(0, 1) ? c8_pkg::OPC_CLS : c8_pkg::OPC_RET;
      1:  op = {c8_pkg::OP_DRW, op[11:4], 4'($urandom_range(0, 4))};
      2:  op = {c8_pkg::OP_MISC, op[11:8], 8'(c8_pkg::MISC_SAVE)};
      3:  op = {c8_pkg::OP_MISC, op[11:8], 8'(c8_pkg::MISC_LOAD)};
      4:  op = {c8_pkg::OP_MISC, op[11:8], 8'(c8_pkg::MISC_BCD)};
      5:  op = {c8_pkg::OP_MISC, op[11:8], 8'(c8_pkg::MISC_WAIT_K)};
      6:  op = {c8_pkg::OP_KEY, op[11:8],
                $urandom_range(0, 1) ? c8_pkg::KEY_SKP : c8_pkg::KEY_SKNP};
      7:  op = {c8_pkg::OP_ALU, op[11:4], 4'($urandom_range(0, 7))};
      8:  op = {c8_pkg::OP_ALU, op[11:4], c8_pkg::ALU_SHL};
      9:  op = {c8_pkg::OP_MISC, op[11:8], 8'(c8_pkg::MISC_FONT)};
      10: op = {c8_pkg::OP_LD_I, op[11:0]};
      default: ;
    endcase
    return op;
  endfunction

  task automatic run_program(int unsigned len, logic [11:0] base);
    logic [15:0]      op;
    c8_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      op = random_opcode();
      if (op[15:12] inside {c8_pkg::OP_JP, c8_pkg::OP_CALL, c8_pkg::OP_JP_V0})
        op[11:0] = base + 12'($urandom_range(0, 16) * 2);
      load_byte(12'(base + 2 * i), op[15:8]);
      load_byte(12'(base + 2 * i + 1), op[7:0]);
    end
    load_byte(12'($urandom), 8'($urandom));
    for (int i = 0; i < 2 * len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = noise_item($urandom_range(0, 9) == 0 ? c8_pkg::MODE_NONE : c8_pkg::MODE_ROW);
        send(it);
      end
      exec_one($urandom_range(0, 3) == 0 ? 16'd0 :
               16'(1 << $urandom_range(0, 15)) | 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0]      dir_ops [24];
    c8_pkg::in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    sent = 0;
    stim_done = 1'b0;
    dir_ops = '{16'h6AFF, 16'h6BFF, 16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h8AB6, 16'h8ABE,
                16'h6F80, 16'h8FFE, 16'hF029, 16'hD015, 16'hD015, 16'hF533, 16'hFF55,
                16'hFF65, 16'h00E0, 16'hD010, 16'hF00A, 16'hE09E, 16'h2210, 16'h5121,
                16'h9121, 16'hB000, 16'hFFFF};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      load_byte(12'(12'h200 + 2 * i), dir_ops[i][15:8]);
      load_byte(12'(12'h200 + 2 * i + 1), dir_ops[i][7:0]);
    end
    load_byte(12'hFFF, 8'hFF);
    for (int i = 0; i < 24; i++) exec_one(i == 17 ? 16'd0 : 16'hFFFF);
    it = noise_item(c8_pkg::MODE_ROW);
    it.row_select = 5'd31;
    send(it);
    it.row_select = 5'd0;
    send(it);
    send(noise_item(c8_pkg::MODE_NONE));
    pause_input();
    while (pending != 0) @(posedge clk);
    while (sent < RandomItems) run_program($urandom_range(4, 16), 12'($urandom_range(0, 4000)));
    pause_input();
    stim_done <= 1'b1;
  end

  initial begin
    int unsigned g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      g = gap_len();
      if ($urandom_range(0, 3) == 0 && g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (stim_done === 1'b1);
    while (pending != 0 && idle_cycles < IdleLimit) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d transactions through load, execute, row read and idle modes,", sent);
    $display("with %0d results checked against the predicted machine state.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Some tests failed");
    $finish;
  end

endmodule
